/* rtl/wdt_pkg.sv */
// Shared types, codes and helpers for the windlass direction tracker.
package wdt_pkg;

    localparam int SampleWidth = 16;
    localparam int TimerWidth  = 16;
    localparam int CfgIdxWidth = 3;
    localparam int CfgWidth    = 16;

    // Register indexes on the configuration port
    localparam logic [CfgIdxWidth-1:0] REG_UP_WINDOW_HIGH      = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_UP_WINDOW_LOW       = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_REED_THRESHOLD      = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_DISPLAY_HOLD_CYCLES = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_SAVE_AFTER_CYCLES   = 3'd4;

    // Reset values of the registers
    localparam logic signed [SampleWidth-1:0] UP_WINDOW_HIGH_RST = 16'sd32767;
    localparam logic signed [SampleWidth-1:0] UP_WINDOW_LOW_RST  = 16'sd4500;
    localparam logic signed [SampleWidth-1:0] REED_THRESHOLD_RST = 16'sd20000;
    localparam logic [TimerWidth-1:0]         DISPLAY_HOLD_RST   = 16'd5;
    localparam logic [TimerWidth-1:0]         SAVE_AFTER_RST     = 16'd10;

    localparam logic [TimerWidth-1:0] TIMER_MAX = '1;

    // Motion codes as seen on the result stream
    localparam logic [1:0] MOTION_CODE_IDLE = 2'd0;
    localparam logic [1:0] MOTION_CODE_UP   = 2'd1;
    localparam logic [1:0] MOTION_CODE_DOWN = 2'd2;

    // Request kinds on s_tuser
    localparam logic REQ_CURRENT = 1'b0;
    localparam logic REQ_REED    = 1'b1;

    typedef enum logic [2:0] {
        MOT_IDLE = 3'b001,
        MOT_UP   = 3'b010,
        MOT_DOWN = 3'b100
    } motion_t;

    typedef struct packed {
        logic signed [SampleWidth-1:0] up_window_high;
        logic signed [SampleWidth-1:0] up_window_low;
        logic signed [SampleWidth-1:0] reed_threshold;
        logic [TimerWidth-1:0]         display_hold_cycles;
        logic [TimerWidth-1:0]         save_after_cycles;
    } cfg_t;

    typedef struct packed {
        motion_t               motion;
        logic                  sign_negative;
        logic [TimerWidth-1:0] cycle_timer;
        logic                  is_saved;
    } track_state_t;

    function automatic logic [1:0] motion_code(motion_t m);
        logic [1:0] code;
        case (m)
            MOT_UP:   code = MOTION_CODE_UP;
            MOT_DOWN: code = MOTION_CODE_DOWN;
            default:  code = MOTION_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

/* rtl/wdt_cfg_regs.sv */
// Configuration register bank of the windlass direction tracker.
module wdt_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [wdt_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [wdt_pkg::CfgWidth-1:0]       cfg_wdata,
    output wdt_pkg::cfg_t                      cfg
);

    wdt_pkg::cfg_t cfg_reg;
    wdt_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                wdt_pkg::REG_UP_WINDOW_HIGH:      cfg_next.up_window_high      = cfg_wdata;
                wdt_pkg::REG_UP_WINDOW_LOW:       cfg_next.up_window_low       = cfg_wdata;
                wdt_pkg::REG_REED_THRESHOLD:      cfg_next.reed_threshold      = cfg_wdata;
                wdt_pkg::REG_DISPLAY_HOLD_CYCLES: cfg_next.display_hold_cycles = cfg_wdata;
                wdt_pkg::REG_SAVE_AFTER_CYCLES:   cfg_next.save_after_cycles   = cfg_wdata;
                default: ; // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.up_window_high      <= wdt_pkg::UP_WINDOW_HIGH_RST;
            cfg_reg.up_window_low       <= wdt_pkg::UP_WINDOW_LOW_RST;
            cfg_reg.reed_threshold      <= wdt_pkg::REED_THRESHOLD_RST;
            cfg_reg.display_hold_cycles <= wdt_pkg::DISPLAY_HOLD_RST;
            cfg_reg.save_after_cycles   <= wdt_pkg::SAVE_AFTER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/wdt_step.sv */
// Next-state logic for one item: up window, down hold, save, idle and reed pulse branches.
module wdt_step (
    input  wdt_pkg::cfg_t                          cfg,
    input  wdt_pkg::track_state_t                  st,
    input  logic                                   req_type,
    input  logic signed [wdt_pkg::SampleWidth-1:0] sample,
    input  logic                                   store_succeeds,
    output wdt_pkg::track_state_t                  st_next,
    output logic                                   save_request
);

    logic                              in_up_window;
    logic                              below_low;
    logic [wdt_pkg::TimerWidth-1:0]    timer_adv;
    logic [wdt_pkg::TimerWidth-1:0]    timer_new;

    assign below_low    = (sample <= cfg.up_window_low);
    assign in_up_window = !below_low && (sample <= cfg.up_window_high);
    // saturating increment
    assign timer_adv    = (st.cycle_timer == wdt_pkg::TIMER_MAX) ? st.cycle_timer
                                                                 : st.cycle_timer + 1'b1;

    always_comb begin
        st_next      = st;
        save_request = 1'b0;
        timer_new    = timer_adv;
        if (req_type == wdt_pkg::REQ_CURRENT) begin
            if (in_up_window) begin
                st_next.motion        = wdt_pkg::MOT_UP;
                st_next.sign_negative = 1'b1;
            end else if (st.motion == wdt_pkg::MOT_DOWN && below_low) begin
                st_next.sign_negative = 1'b0;
                st_next.cycle_timer   = timer_adv;
                if (timer_adv >= cfg.display_hold_cycles) begin
                    st_next.motion = wdt_pkg::MOT_IDLE;
                end
            end else if (!st.is_saved && st.cycle_timer == cfg.save_after_cycles) begin
                st_next.motion        = wdt_pkg::MOT_IDLE;
                st_next.sign_negative = 1'b0;
                st_next.is_saved      = store_succeeds;
                save_request          = 1'b1;
                if (store_succeeds) begin
                    st_next.cycle_timer = '0;
                end
            end else begin
                timer_new             = st.is_saved ? '0 : timer_adv;
                st_next.cycle_timer   = timer_new;
                st_next.sign_negative = 1'b0;
                if (timer_new >= cfg.display_hold_cycles) begin
                    st_next.motion = wdt_pkg::MOT_IDLE;
                end
            end
        end else if (sample >= cfg.reed_threshold) begin
            // gypsy pulse: count becomes unsaved, sign untouched
            st_next.is_saved    = 1'b0;
            st_next.cycle_timer = '0;
            if (st.motion == wdt_pkg::MOT_IDLE) begin
                st_next.motion = wdt_pkg::MOT_DOWN;
            end
        end
    end

endmodule

/* rtl/windlass_direction_tracker.sv */
// Top level of the windlass direction tracker: input stage, tracker state, result stage.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tuser: req_type; tdata: sample, store_succeeds
//  m_       out  m_tvalid/m_tready  tdata: motion_state, counting_negative,
//                                          save_request, sample_echo
//  cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// One item per cycle sustained while the m_ side accepts; an item passes the input
// register, then the tracker update into the result register, before m_tvalid
// rises and the m_ transfer can take place.
// The tracker state is updated as an item moves into the result register.
// A stalled m_ side holds the result; s_tready drops only once the input
// register is also full. Reset is synchronous, active low.
module windlass_direction_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // [15:0] sample, [16] store_succeeds
    input  logic [0:0]                          s_tuser,  // [0] req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,  // [1:0] motion_state,
                                                          // [2] counting_negative,
                                                          // [3] save_request,
                                                          // [19:4] sample_echo
    input  logic                                cfg_wr_en,
    input  logic [wdt_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [wdt_pkg::CfgWidth-1:0]        cfg_wdata
);

    wdt_pkg::cfg_t          cfg;
    wdt_pkg::track_state_t  state_reg;
    wdt_pkg::track_state_t  state_next;

    logic                                   in_valid_reg;
    logic                                   in_req_reg;
    logic signed [wdt_pkg::SampleWidth-1:0] in_sample_reg;
    logic                                   in_ok_reg;

    logic                                   out_valid_reg;
    logic [1:0]                             out_motion_reg;
    logic                                   out_neg_reg;
    logic                                   out_save_reg;
    logic [wdt_pkg::SampleWidth-1:0]        out_sample_reg;

    logic save_request;
    logic advance;
    logic s_transfer;

    assign advance    = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || advance;
    assign s_transfer = s_tvalid && s_tready;

    wdt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wdt_step u_step (
        .cfg            (cfg),
        .st             (state_reg),
        .req_type       (in_req_reg),
        .sample         (in_sample_reg),
        .store_succeeds (in_ok_reg),
        .st_next        (state_next),
        .save_request   (save_request)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_transfer) begin
            in_req_reg    <= s_tuser[0];
            in_sample_reg <= s_tdata[15:0];
            in_ok_reg     <= s_tdata[16];
        end
    end

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.motion        <= wdt_pkg::MOT_IDLE;
            state_reg.sign_negative <= 1'b0;
            state_reg.cycle_timer   <= '0;
            state_reg.is_saved      <= 1'b1;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_motion_reg <= wdt_pkg::motion_code(state_next.motion);
            out_neg_reg    <= state_next.sign_negative;
            out_save_reg   <= save_request;
            out_sample_reg <= in_sample_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_sample_reg, out_save_reg, out_neg_reg, out_motion_reg};

    // A negative count is only ever left behind by an up-window sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.sign_negative |-> state_reg.motion == wdt_pkg::MOT_UP)
        else $error("negative sign while not winching up");

    // A save request always leaves the windlass idle and counting up.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |->
            (m_tdata[1:0] == wdt_pkg::MOTION_CODE_IDLE && !m_tdata[2]))
        else $error("save request with motion not idle");

    // No state update while the result is held back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && in_valid_reg) |=> $stable(state_reg))
        else $error("tracker state moved during output stall");

    // Each item entering the result register came through the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(out_valid_reg)) |-> $past(in_valid_reg))
        else $error("result produced without an input item");

endmodule

/* tb/tracker_check_pkg.sv */
// Scoreboard for the windlass direction tracker: motion prediction and result checks.
`timescale 1ns / 1ps

package tracker_check_pkg;

    import wdt_pkg::*;

    typedef struct packed {
        logic [1:0]            motion;
        logic                  negative;
        logic                  save_req;
        logic [SampleWidth-1:0] echo;
    } motion_report_t;

    class tracker_scoreboard;

        // mirrored registers
        logic signed [SampleWidth-1:0] win_high;
        logic signed [SampleWidth-1:0] win_low;
        logic signed [SampleWidth-1:0] reed_thr;
        logic [TimerWidth-1:0]         hold_cycles;
        logic [TimerWidth-1:0]         save_after;

        // predicted tracker state
        logic [1:0]            motion;
        logic                  sign_neg;
        logic [TimerWidth-1:0] timer;
        logic                  saved;

        motion_report_t pending_reports[$];
        int             errors;

        function new();
            win_high    = UP_WINDOW_HIGH_RST;
            win_low     = UP_WINDOW_LOW_RST;
            reed_thr    = REED_THRESHOLD_RST;
            hold_cycles = DISPLAY_HOLD_RST;
            save_after  = SAVE_AFTER_RST;
            motion      = MOTION_CODE_IDLE;
            sign_neg    = 1'b0;
            timer       = '0;
            saved       = 1'b1;
            errors      = 0;
        endfunction

        function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
            case (idx)
                REG_UP_WINDOW_HIGH:      win_high    = val;
                REG_UP_WINDOW_LOW:       win_low     = val;
                REG_REED_THRESHOLD:      reed_thr    = val;
                REG_DISPLAY_HOLD_CYCLES: hold_cycles = val;
                REG_SAVE_AFTER_CYCLES:   save_after  = val;
                default: ;
            endcase
        endfunction

        // saturating advance
        function logic [TimerWidth-1:0] timer_step(logic [TimerWidth-1:0] t);
            return (t == TIMER_MAX) ? t : t + 1'b1;
        endfunction

        function void note_request(logic kind, logic signed [SampleWidth-1:0] smp, logic ok);
            motion_report_t r;
            r.save_req = 1'b0;
            if (kind == REQ_CURRENT) begin
                if (smp > win_low && smp <= win_high) begin
                    motion   = MOTION_CODE_UP;
                    sign_neg = 1'b1;
                end else if (motion == MOTION_CODE_DOWN && smp <= win_low) begin
                    sign_neg = 1'b0;
                    timer    = timer_step(timer);
                    if (timer >= hold_cycles) motion = MOTION_CODE_IDLE;
                end else if (!saved && timer == save_after) begin
                    motion     = MOTION_CODE_IDLE;
                    sign_neg   = 1'b0;
                    r.save_req = 1'b1;
                    saved      = ok;
                    if (ok) timer = '0;
                end else begin
                    timer = saved ? '0 : timer_step(timer);
                    if (timer >= hold_cycles) motion = MOTION_CODE_IDLE;
                    sign_neg = 1'b0;
                end
            end else if (smp >= reed_thr) begin
                saved = 1'b0;
                timer = '0;
                if (motion == MOTION_CODE_IDLE) motion = MOTION_CODE_DOWN;
            end
            r.motion   = motion;
            r.negative = sign_neg;
            r.echo     = smp;
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [23:0] tdata);
            motion_report_t want;
            if (pending_reports.size() == 0) begin
                $error("result with nothing awaited: tdata %h", tdata);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("motion_state", 16'(want.motion), 16'(tdata[1:0]));
            compare_field("counting_negative", 16'(want.negative), 16'(tdata[2]));
            compare_field("save_request", 16'(want.save_req), 16'(tdata[3]));
            compare_field("sample_echo", want.echo, tdata[19:4]);
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench for the windlass direction tracker.
`timescale 1ns / 1ps

module tb_top;

    import wdt_pkg::*;
    import tracker_check_pkg::*;

    localparam logic [CfgIdxWidth-1:0] REG_INDEX_LAST = REG_SAVE_AFTER_CYCLES;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [23:0]            s_tdata;   // [15:0] sample, [16] store_succeeds
    logic [0:0]             s_tuser;   // [0] req_type
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;   // [1:0] motion_state, [2] counting_negative,
                                       // [3] save_request, [19:4] sample_echo
    logic                   cfg_wr_en;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CfgWidth-1:0]    cfg_wdata;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_off_left = 0;

    tracker_scoreboard board = new();

    windlass_direction_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // result side: random stalls, plus a counted hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_report(m_tdata);
    end

    initial begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int rand_between(int a, int b);
        return a + int'($urandom_range(b - a));
    endfunction

    function automatic logic signed [15:0] pick_current();
        int lo, hi, roll;
        lo   = board.win_low;
        hi   = board.win_high;
        roll = $urandom_range(99);
        if (roll < 60) return 16'(rand_between(-32768, lo));
        if (roll < 70 && lo < hi) return 16'(rand_between(lo + 1, hi));
        if (roll < 78 && hi < 32767) return 16'(rand_between(hi + 1, 32767));
        if (roll < 92) begin
            case ($urandom_range(3))
                0: return 16'(lo);
                1: return 16'(lo + 1);
                2: return 16'(hi);
                default: return 16'(hi + 1);
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] pick_reed(logic pulse);
        int thr;
        thr = board.reed_thr;
        if (pulse) return 16'(rand_between(thr, 32767));
        if (thr > -32768) return 16'(rand_between(-32768, thr - 1));
        return 16'($urandom);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic kind, input logic signed [15:0] smp, input logic ok);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            s_tuser  <= 1'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, ok, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(kind, smp, ok);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        board.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic signed [15:0] hi, input logic signed [15:0] lo,
                                input logic signed [15:0] thr, input logic [15:0] hold,
                                input logic [15:0] save);
        write_reg(REG_UP_WINDOW_HIGH, hi);
        write_reg(REG_UP_WINDOW_LOW, lo);
        write_reg(REG_REED_THRESHOLD, thr);
        write_reg(REG_DISPLAY_HOLD_CYCLES, hold);
        write_reg(REG_SAVE_AFTER_CYCLES, save);
        // an index past the last register must leave everything alone
        write_reg(CfgIdxWidth'(REG_INDEX_LAST + 1 + $urandom_range(2)), CfgWidth'($urandom));
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // mostly gypsy pulses followed by runs of current samples, some plain noise
    task automatic run_random(input int count);
        int sent, run_len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                send_item(REQ_REED, pick_reed(1'b1), 1'($urandom));
                run_len = $urandom_range(24);
                sent += run_len + 1;
                repeat (run_len) begin
                    if ($urandom_range(19) == 0) begin
                        send_item(REQ_REED, pick_reed(1'b0), 1'($urandom));
                    end else begin
                        send_item(REQ_CURRENT, pick_current(), 1'($urandom));
                    end
                end
            end else begin
                send_item(1'($urandom), 16'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        int phase;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed walk at the reset register values
        send_item(REQ_CURRENT, 16'sd0, 1'b1);
        send_item(REQ_CURRENT, 16'sh7FFF, 1'b1);
        send_item(REQ_CURRENT, 16'sd4501, 1'b0);
        send_item(REQ_CURRENT, 16'sd4500, 1'b1);     // on the exclusive bound
        send_item(REQ_REED, 16'sd19999, 1'b1);       // just short of a pulse
        send_item(REQ_REED, 16'sd20000, 1'b0);       // pulse while up: stays up
        send_item(REQ_CURRENT, 16'sh8000, 1'b1);
        repeat (4) send_item(REQ_CURRENT, -16'sd1, 1'b1);
        send_item(REQ_REED, 16'sh7FFF, 1'b1);        // idle -> down
        repeat (5) send_item(REQ_CURRENT, 16'sd100, 1'b0);
        repeat (5) send_item(REQ_CURRENT, 16'sd0, 1'b1);
        send_item(REQ_CURRENT, 16'sd0, 1'b0);        // save fails, timer kept
        send_item(REQ_CURRENT, 16'sd0, 1'b1);        // retried, succeeds
        send_item(REQ_REED, 16'sh8000, 1'b1);

        for (phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: program_regs(16'sd12000, -16'sd3000, 16'sd0, 16'd3, 16'd6);
                1: program_regs(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd0, 16'd0);
                2: program_regs(16'sh8000, 16'sh7FFF, 16'sh8000, TIMER_MAX, TIMER_MAX);
                3: program_regs(16'sd100, 16'sd100, 16'sd5000, 16'd2, 16'd4);
                default: program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom_range(12)), 16'($urandom_range(16)));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            // long receiver hold-off while items keep coming, to back up the input
            if (phase == 0) hold_off_left = 80;
            run_random(210);
        end

        // hold and save counts at the top of the timer range
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
        program_regs(16'sh7FFF, 16'sd0, 16'sd20000, TIMER_MAX, TIMER_MAX);
        send_item(REQ_REED, 16'sh7FFF, 1'b1);
        repeat (3) send_item(REQ_CURRENT, -16'sd5, 1'b1);
        send_item(REQ_CURRENT, 16'sd0, 1'b0);
        send_item(REQ_CURRENT, 16'sd0, 1'b1);

        drain();
        repeat (6) @(posedge aclk);
        if (board.outstanding() != 0) $error("%0d results never arrived", board.outstanding());
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
